// ===== rtl/core/ppi_pkg.sv =====
`default_nettype none
package ppi_pkg;

   localparam int SLOT_COUNT = 64;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int CNT_W      = SLOT_W + 1;
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PW    = $clog2(FIFO_DEPTH);

   // register indexes on the csr port
   localparam logic [2:0] CSR_EMISSION_RATE = 3'd0;
   localparam logic [2:0] CSR_LIFESPAN      = 3'd1;
   localparam logic [2:0] CSR_INV_LIFESPAN  = 3'd2;
   localparam logic [2:0] CSR_GRAVITY_X     = 3'd3;
   localparam logic [2:0] CSR_GRAVITY_Y     = 3'd4;
   localparam logic [2:0] CSR_GRAVITY_Z     = 3'd5;
   localparam logic [2:0] CSR_EMITTING      = 3'd6;
   localparam logic [2:0] CSR_RUNNING       = 3'd7;

   typedef struct packed {
      logic [30:0]        emission_rate;
      logic [30:0]        lifespan;
      logic [30:0]        inv_lifespan;
      logic signed [31:0] gravity_x;
      logic signed [31:0] gravity_y;
      logic signed [31:0] gravity_z;
      logic               emitting_enable;
      logic               running_enable;
   } cfg_type;

   // one classified tick, handed from front to back
   typedef struct packed {
      logic [20:0]        dt;
      logic signed [31:0] ex;
      logic signed [31:0] ey;
      logic [SLOT_W-1:0]  start;
      logic [CNT_W-1:0]   num;
      logic [47:0]        birth;
      logic [47:0]        now;
      logic               running;
   } tick_type;

   // one slot as kept in the slot memory
   typedef struct packed {
      logic               used;
      logic [47:0]        birth;
      logic signed [31:0] vz;
      logic signed [31:0] vy;
      logic signed [31:0] vx;
      logic signed [31:0] pz;
      logic signed [31:0] py;
      logic signed [31:0] px;
   } slot_type;

   localparam int SLOT_BITS = $bits(slot_type);

   function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
      logic signed [31:0] r;
      if (v > 38'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -38'sd2147483648) r = 32'sh80000000;
      else r = $signed(v[31:0]);
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ppi_ram.sv =====
`default_nettype none
module ppi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      if (re) rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== rtl/core/ppi_front.sv =====
`default_nettype none
module ppi_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [87:0]       req_tdata,
   input  ppi_pkg::cfg_type  cfg,
   output logic              push_valid,
   input  logic              push_ready,
   output ppi_pkg::tick_type push_data
);
   import ppi_pkg::*;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_MUL  = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [20:0]        dt_ff;
   logic signed [31:0] ex_ff, ey_ff;
   logic [51:0]        prod_ff;
   logic [47:0]        accum_ff, accum_in;
   logic [SLOT_W-1:0]  next_ff, next_in;
   logic [47:0]        time_ff, time_in;
   logic               emit;
   logic [31:0]        count;
   logic [CNT_W-1:0]   num;
   logic [47:0]        time_adv;

   assign req_tready = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);

   // emission count and time advance for the held tick
   always_comb begin
      emit     = cfg.emitting_enable & cfg.running_enable;
      accum_in = accum_ff + {12'd0, prod_ff[51:16]};
      count    = accum_in[47:16] - accum_ff[47:16];
      if (!emit) num = '0;
      else if (count >= 32'(SLOT_COUNT)) num = CNT_W'(SLOT_COUNT);
      else num = count[CNT_W-1:0];
      time_adv = time_ff + {27'd0, dt_ff};
      next_in  = next_ff + count[SLOT_W-1:0];
      time_in  = cfg.running_enable ? time_adv : time_ff;
   end

   always_comb begin
      push_data.dt      = dt_ff;
      push_data.ex      = ex_ff;
      push_data.ey      = ey_ff;
      push_data.start   = next_ff;
      push_data.num     = num;
      push_data.birth   = time_ff;
      push_data.now     = time_in;
      push_data.running = cfg.running_enable;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: if (req_tvalid) state_in = F_MUL;
         F_MUL: state_in = F_PUSH;
         F_PUSH: if (push_ready) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         accum_ff <= '0;
         next_ff  <= '0;
         time_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (push_valid && push_ready) begin
            time_ff <= time_in;
            if (emit) begin
               accum_ff <= accum_in;
               next_ff  <= next_in;
            end
         end
      end
   end

   // payload capture and emission rate product
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         dt_ff <= req_tdata[20:0];
         ex_ff <= $signed(req_tdata[52:21]);
         ey_ff <= $signed(req_tdata[84:53]);
      end
      if (state_ff == F_MUL) prod_ff <= dt_ff * cfg.emission_rate;
   end
endmodule
`default_nettype wire

// ===== rtl/core/ppi_tick_fifo.sv =====
`default_nettype none
module ppi_tick_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  ppi_pkg::tick_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output ppi_pkg::tick_type pop_data
);
   import ppi_pkg::*;

   tick_type           entry_ff [FIFO_DEPTH];
   logic [FIFO_PW-1:0] wr_ff, rd_ff;
   logic [FIFO_PW:0]   fill_ff;
   logic               do_push, do_pop;

   assign push_ready = (fill_ff != (FIFO_PW+1)'(FIFO_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = entry_ff[rd_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         if (do_push) wr_ff <= (wr_ff == FIFO_PW'(FIFO_DEPTH-1)) ? '0 : wr_ff + 1'b1;
         if (do_pop) rd_ff <= (rd_ff == FIFO_PW'(FIFO_DEPTH-1)) ? '0 : rd_ff + 1'b1;
         fill_ff <= fill_ff + (FIFO_PW+1)'(do_push) - (FIFO_PW+1)'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ff] <= push_data;
   end
endmodule
`default_nettype wire

// ===== rtl/core/ppi_back.sv =====
`default_nettype none
module ppi_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  ppi_pkg::tick_type pop_data,
   input  ppi_pkg::cfg_type  cfg,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [143:0]      rsp_tdata,
   output logic              rsp_tlast
);
   import ppi_pkg::*;

   localparam logic [1:0] B_IDLE  = 2'd0;
   localparam logic [1:0] B_GRAV  = 2'd1;
   localparam logic [1:0] B_SWEEP = 2'd2;
   localparam logic [1:0] B_DRAIN = 2'd3;

   logic [1:0]         state_ff, state_in;
   tick_type           tick_ff;
   logic [1:0]         gsel_ff;
   logic signed [37:0] gdt_ff [3];
   logic signed [31:0] gsel_val;
   logic signed [53:0] gprod;
   logic [SLOT_W-1:0]  idx_ff;
   logic [SLOT_COUNT-1:0] written_ff;
   logic               adv, issue, last_idx;

   // stage 1: memory data
   logic               s1_v_ff;
   logic [SLOT_W-1:0]  s1_idx_ff;
   logic [SLOT_BITS-1:0] rd_word;
   slot_type           s1_slot;
   logic [SLOT_W-1:0]  s1_off;
   logic               s1_hit;
   logic signed [31:0] s1_pos [3];
   logic signed [31:0] s1_vel [3];
   logic signed [31:0] s1_vin [3];
   logic [47:0]        s1_age;
   logic               s1_alive;

   // stage 2: velocity done
   logic               s2_v_ff;
   logic [SLOT_W-1:0]  s2_idx_ff;
   logic signed [31:0] s2_pos_ff [3];
   logic signed [31:0] s2_vel_ff [3];
   logic [47:0]        s2_birth_ff;
   logic               s2_used_ff, s2_alive_ff;
   logic [47:0]        s2_age_ff;
   logic signed [53:0] s2_prod [3];

   // stage 3: products ready
   logic               s3_v_ff;
   logic [SLOT_W-1:0]  s3_idx_ff;
   logic signed [31:0] s3_pos_ff [3];
   logic signed [31:0] s3_vel_ff [3];
   logic signed [37:0] s3_pm_ff [3];
   logic [47:0]        s3_birth_ff;
   logic               s3_used_ff, s3_alive_ff;
   logic [54:0]        s3_ahi_ff, s3_alo_ff;
   logic signed [31:0] s3_pnew [3];
   logic [63:0]        s3_r;
   logic [30:0]        s3_age;
   slot_type           wr_slot;
   logic               we;

   // output register
   logic               rsp_tvalid_ff;
   logic [143:0]       rsp_tdata_ff;
   logic               rsp_tlast_ff;
   logic [CNT_W-1:0]   alive_cnt_ff, alive_cnt_in;

   assign adv       = !rsp_tvalid_ff || rsp_tready;
   assign pop_ready = (state_ff == B_IDLE);
   assign issue     = (state_ff == B_SWEEP) && adv;
   assign last_idx  = (idx_ff == SLOT_W'(SLOT_COUNT-1));

   // gravity times dt, one component a cycle
   always_comb begin
      unique case (gsel_ff)
         2'd0: gsel_val = cfg.gravity_x;
         2'd1: gsel_val = cfg.gravity_y;
         default: gsel_val = cfg.gravity_z;
      endcase
      gprod = gsel_val * $signed({1'b0, tick_ff.dt});
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (pop_valid) state_in = B_GRAV;
         B_GRAV: if (gsel_ff == 2'd2) state_in = B_SWEEP;
         B_SWEEP: if (issue && last_idx) state_in = B_DRAIN;
         B_DRAIN: if (!s1_v_ff && !s2_v_ff && !s3_v_ff) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   ppi_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOT_COUNT)) u_slot_ram (
      .clock (clock),
      .we    (we),
      .waddr (s3_idx_ff),
      .wdata (wr_slot),
      .re    (issue),
      .raddr (idx_ff),
      .rdata (rd_word)
   );

   // stage 1: emission override, velocity step, age and liveness
   always_comb begin
      s1_slot = written_ff[s1_idx_ff] ? slot_type'(rd_word) : '0;
      s1_off  = s1_idx_ff - tick_ff.start;
      s1_hit  = (tick_ff.num == CNT_W'(SLOT_COUNT)) || ({1'b0, s1_off} < tick_ff.num);
      if (s1_hit) begin
         s1_slot.px    = tick_ff.ex;
         s1_slot.py    = tick_ff.ey;
         s1_slot.pz    = '0;
         s1_slot.vx    = '0;
         s1_slot.vy    = '0;
         s1_slot.vz    = '0;
         s1_slot.birth = tick_ff.birth;
         s1_slot.used  = 1'b1;
      end
      s1_pos[0] = s1_slot.px;
      s1_pos[1] = s1_slot.py;
      s1_pos[2] = s1_slot.pz;
      s1_vin[0] = s1_slot.vx;
      s1_vin[1] = s1_slot.vy;
      s1_vin[2] = s1_slot.vz;
      for (int k = 0; k < 3; k++) begin
         s1_vel[k] = tick_ff.running
                   ? sat32($signed({{6{s1_vin[k][31]}}, s1_vin[k]}) + gdt_ff[k])
                   : s1_vin[k];
      end
      s1_age   = (tick_ff.now < s1_slot.birth) ? '0 : tick_ff.now - s1_slot.birth;
      s1_alive = s1_slot.used &&
                 (({1'b0, s1_slot.birth} + {18'd0, cfg.lifespan}) > {1'b0, tick_ff.now});
   end

   // stage 2: position and age products
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s2_prod[k] = s2_vel_ff[k] * $signed({1'b0, tick_ff.dt});
      end
   end

   // stage 3: position step, age saturation, write back
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s3_pnew[k] = tick_ff.running
                    ? sat32($signed({{6{s3_pos_ff[k][31]}}, s3_pos_ff[k]}) + s3_pm_ff[k])
                    : s3_pos_ff[k];
      end
      s3_r   = {1'b0, s3_ahi_ff, 8'd0} + {25'd0, s3_alo_ff[54:16]};
      s3_age = (s3_r > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : s3_r[30:0];
      wr_slot.px    = s3_pnew[0];
      wr_slot.py    = s3_pnew[1];
      wr_slot.pz    = s3_pnew[2];
      wr_slot.vx    = s3_vel_ff[0];
      wr_slot.vy    = s3_vel_ff[1];
      wr_slot.vz    = s3_vel_ff[2];
      wr_slot.birth = s3_birth_ff;
      wr_slot.used  = s3_used_ff;
      we            = s3_v_ff && adv && tick_ff.running;
      alive_cnt_in  = alive_cnt_ff + CNT_W'(s3_alive_ff);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         s3_v_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         written_ff    <= '0;
         alive_cnt_ff  <= '0;
         gsel_ff       <= '0;
         idx_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (pop_valid && pop_ready) begin
            gsel_ff      <= '0;
            idx_ff       <= '0;
            alive_cnt_ff <= '0;
         end
         if (state_ff == B_GRAV) gsel_ff <= gsel_ff + 2'd1;
         if (issue) idx_ff <= idx_ff + 1'b1;
         if (adv) begin
            s1_v_ff       <= issue;
            s2_v_ff       <= s1_v_ff;
            s3_v_ff       <= s2_v_ff;
            rsp_tvalid_ff <= s3_v_ff;
            if (s3_v_ff) alive_cnt_ff <= alive_cnt_in;
         end
         if (we) written_ff[s3_idx_ff] <= 1'b1;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) tick_ff <= pop_data;
      if (state_ff == B_GRAV) gdt_ff[gsel_ff] <= 38'(gprod >>> 16);
      if (adv) begin
         s1_idx_ff   <= idx_ff;
         s2_idx_ff   <= s1_idx_ff;
         s2_birth_ff <= s1_slot.birth;
         s2_used_ff  <= s1_slot.used;
         s2_alive_ff <= s1_alive;
         s2_age_ff   <= s1_age;
         s3_idx_ff   <= s2_idx_ff;
         s3_birth_ff <= s2_birth_ff;
         s3_used_ff  <= s2_used_ff;
         s3_alive_ff <= s2_alive_ff;
         s3_ahi_ff   <= s2_age_ff[47:24] * cfg.inv_lifespan;
         s3_alo_ff   <= s2_age_ff[23:0] * cfg.inv_lifespan;
         for (int k = 0; k < 3; k++) begin
            s2_pos_ff[k] <= s1_pos[k];
            s2_vel_ff[k] <= s1_vel[k];
            s3_pos_ff[k] <= s2_pos_ff[k];
            s3_vel_ff[k] <= s2_vel_ff[k];
            s3_pm_ff[k]  <= 38'(s2_prod[k] >>> 16);
         end
         if (s3_v_ff) begin
            rsp_tlast_ff <= (s3_idx_ff == SLOT_W'(SLOT_COUNT-1));
            rsp_tdata_ff <= {3'd0,
                             (s3_idx_ff == SLOT_W'(SLOT_COUNT-1)) ? alive_cnt_in : '0,
                             s3_age, s3_alive_ff,
                             s3_pnew[2], s3_pnew[1], s3_pnew[0], s3_idx_ff};
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
endmodule
`default_nettype wire

// ===== rtl/core/particle_pool_integrator_unit.sv =====
`default_nettype none
// A tick's first slot transaction follows the front (capture, multiply, push), the
//   tick queue, the gravity products for three components and the slot pipeline.
// The back takes one slot a cycle through the single read port of the slot memory
//   while the output is not stalled, and drains the pipeline before the next tick.
// The front takes a new tick once the last is pushed; two ticks wait in the queue.
// Reset (synchronous, active high) restores register defaults, clears time, emission
//   state and slot valid bits; unwritten slots read as zero, so no clearing pass.
module particle_pool_integrator_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [87:0]   req_tdata,   // delta_time, emit_x, emit_y
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [143:0]  rsp_tdata,   // slot_number, out_pos_x, out_pos_y, out_pos_z,
                                      // is_alive, normalized_age, active_count
   output logic          rsp_tlast,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_data
);
   import ppi_pkg::*;

   cfg_type  cfg_ff;
   logic     push_valid, push_ready, pop_valid, pop_ready;
   tick_type push_data, pop_data;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.emission_rate   <= 31'd655360;
         cfg_ff.lifespan        <= 31'd655360;
         cfg_ff.inv_lifespan    <= 31'd6554;
         cfg_ff.gravity_x       <= '0;
         cfg_ff.gravity_y       <= -32'sd642908;
         cfg_ff.gravity_z       <= '0;
         cfg_ff.emitting_enable <= 1'b1;
         cfg_ff.running_enable  <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_EMISSION_RATE: cfg_ff.emission_rate   <= csr_data[30:0];
            CSR_LIFESPAN:      cfg_ff.lifespan        <= csr_data[30:0];
            CSR_INV_LIFESPAN:  cfg_ff.inv_lifespan    <= csr_data[30:0];
            CSR_GRAVITY_X:     cfg_ff.gravity_x       <= $signed(csr_data);
            CSR_GRAVITY_Y:     cfg_ff.gravity_y       <= $signed(csr_data);
            CSR_GRAVITY_Z:     cfg_ff.gravity_z       <= $signed(csr_data);
            CSR_EMITTING:      cfg_ff.emitting_enable <= csr_data[0];
            CSR_RUNNING:       cfg_ff.running_enable  <= csr_data[0];
            default: ;
         endcase
      end
   end

   ppi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ppi_tick_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ppi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .cfg        (cfg_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule
`default_nettype wire

// ===== rtl/core/ppi_checker.sv =====
`default_nettype none
module ppi_checker (
   input logic          clock,
   input logic          reset,
   input logic          req_tvalid,
   input logic          req_tready,
   input logic [87:0]   req_tdata,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [143:0]  rsp_tdata,
   input logic          rsp_tlast,
   input logic          csr_valid,
   input logic          csr_ready,
   input logic [2:0]    csr_index,
   input logic [31:0]   csr_data
);
   // a stalled result transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed under stall");

   // nothing is offered right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // alive count only rides on the closing slot
   a_count_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[140:134] == 7'd0)
      else $error("active count on a non-final slot");

   // the closing slot of a tick is the highest slot
   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[5:0] == 6'd63)
      else $error("tick closed on the wrong slot");
endmodule

bind particle_pool_integrator_unit ppi_checker u_ppi_checker (.*);
`default_nettype wire

// ===== sim/particle_pool_integrator_unit_tb.sv =====
`timescale 1ns / 1ps
module particle_pool_integrator_unit_tb;
   import ppi_pkg::*;

   // one expected slot transaction
   typedef struct {
      logic [5:0]         slot;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic               alive;
      logic [30:0]        age;
      logic [6:0]         count;
      logic               last;
   } slot_report_type;

   // particle pool predictor and result checker
   class pool_scoreboard;
      logic [30:0]        rate, life, inv_life;
      logic signed [31:0] grav [3];
      logic               emitting, running;
      logic signed [31:0] pos [64][3];
      logic signed [31:0] vel [64][3];
      logic [47:0]        born [64];
      logic               used [64];
      logic [47:0]        now, accum;
      logic [5:0]         ring_ptr;
      slot_report_type    pending_slots [$];
      int                 errors, checked, ticks;

      function void reset_state();
         rate = 31'd655360; life = 31'd655360; inv_life = 31'd6554;
         grav[0] = '0; grav[1] = -32'sd642908; grav[2] = '0;
         emitting = 1'b1; running = 1'b1;
         foreach (used[i]) begin
            used[i] = 1'b0; born[i] = '0;
            for (int k = 0; k < 3; k++) begin
               pos[i][k] = '0; vel[i][k] = '0;
            end
         end
         now = '0; accum = '0; ring_ptr = '0;
         pending_slots.delete();
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] d);
         case (idx)
            CSR_EMISSION_RATE: rate = d[30:0];
            CSR_LIFESPAN:      life = d[30:0];
            CSR_INV_LIFESPAN:  inv_life = d[30:0];
            CSR_GRAVITY_X:     grav[0] = d;
            CSR_GRAVITY_Y:     grav[1] = d;
            CSR_GRAVITY_Z:     grav[2] = d;
            CSR_EMITTING:      emitting = d[0];
            CSR_RUNNING:       running = d[0];
            default: ;
         endcase
      endfunction

      // floor(v * dt / 2^16)
      function longint scale_dt(logic signed [31:0] v, logic [20:0] dt);
         longint a, b;
         a = longint'(v);
         b = longint'(dt);
         return (a * b) >>> 16;
      endfunction

      function logic signed [31:0] clamp32(longint v);
         if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      // advance the pool by one tick and queue its 64 slot reports
      function void note_tick(logic [20:0] dt, logic signed [31:0] ex,
                              logic signed [31:0] ey);
         logic [31:0]        old_int, cnt;
         logic [63:0]        incr, span, r, age, hi, lo;
         logic [5:0]         s;
         int                 n, alive_total;
         slot_report_type    rep;
         ticks++;
         if (emitting && running) begin
            old_int = accum[47:16];
            incr = (64'(dt) * 64'(rate)) >> 16;
            accum = accum + incr[47:0];
            cnt = accum[47:16] - old_int;
            n = (cnt < 64) ? cnt : 64;
            s = ring_ptr;
            for (int i = 0; i < n; i++) begin
               pos[s][0] = ex; pos[s][1] = ey; pos[s][2] = '0;
               for (int k = 0; k < 3; k++) vel[s][k] = '0;
               born[s] = now;
               used[s] = 1'b1;
               s = s + 6'd1;
            end
            ring_ptr = ring_ptr + cnt[5:0];
         end
         if (running) begin
            now = now + 48'(dt);
            for (int i = 0; i < 64; i++)
               for (int k = 0; k < 3; k++) begin
                  vel[i][k] = clamp32(longint'(vel[i][k]) + scale_dt(grav[k], dt));
                  pos[i][k] = clamp32(longint'(pos[i][k]) + scale_dt(vel[i][k], dt));
               end
         end
         alive_total = 0;
         for (int i = 0; i < 64; i++) begin
            span = 64'(born[i]) + 64'(life);
            rep.slot = 6'(i);
            rep.px = pos[i][0]; rep.py = pos[i][1]; rep.pz = pos[i][2];
            rep.alive = used[i] && (span > 64'(now));
            if (rep.alive) alive_total++;
            if (now < born[i]) r = '0;
            else begin
               age = 64'(now - born[i]);
               hi = age >> 24;
               lo = age & 64'hFFFFFF;
               r = ((hi * 64'(inv_life)) << 8) + ((lo * 64'(inv_life)) >> 16);
               if (r > 64'h7FFFFFFF) r = 64'h7FFFFFFF;
            end
            rep.age = r[30:0];
            rep.count = (i == 63) ? alive_total[6:0] : 7'd0;
            rep.last = (i == 63);
            pending_slots.push_back(rep);
         end
      endfunction

      function void check_rsp(logic [143:0] d, logic tl);
         slot_report_type e;
         if (pending_slots.size() == 0) begin
            $display("%0t: unexpected slot transaction, actual %h last %b", $realtime, d, tl);
            errors++;
            return;
         end
         e = pending_slots.pop_front();
         checked++;
         if (d[5:0] !== e.slot || d[37:6] !== e.px || d[69:38] !== e.py ||
             d[101:70] !== e.pz || d[102] !== e.alive || d[133:103] !== e.age ||
             d[140:134] !== e.count || tl !== e.last) begin
            errors++;
            $display("%0t: slot mismatch, expected slot %0d pos %h %h %h %s",
                     $realtime, e.slot, e.px, e.py, e.pz,
                     $sformatf("alive %b age %h cnt %0d last %b",
                               e.alive, e.age, e.count, e.last));
            $display("%0t:                 actual slot %0d pos %h %h %h %s",
                     $realtime, d[5:0], d[37:6], d[69:38], d[101:70],
                     $sformatf("alive %b age %h cnt %0d last %b",
                               d[102], d[133:103], d[140:134], tl));
         end
      endfunction
   endclass

   localparam int STALL_LIMIT = 5000;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [87:0]   req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [143:0]  rsp_tdata;
   logic          rsp_tlast;
   logic          csr_valid = 0;
   logic          csr_ready;
   logic [2:0]    csr_index = '0;
   logic [31:0]   csr_data = '0;

   pool_scoreboard pool = new();
   bit  quiet_stretch = 0;
   int  hold_request = 0;
   int  hold_left = 0;
   int  idle_count = 0;

   particle_pool_integrator_unit u_top (.*);

   always #10 clock = ~clock;

   // receiver: random back-pressure plus one long hold-off
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet_stretch || ($urandom_range(99) >= 6);
      end
   end

   // transaction monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) pool.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready)
            pool.note_tick(req_tdata[20:0], req_tdata[52:21], req_tdata[84:53]);
         if (rsp_tvalid && rsp_tready) pool.check_rsp(rsp_tdata, rsp_tlast);
         if ((csr_valid && csr_ready) || (req_tvalid && req_tready) ||
             (rsp_tvalid && rsp_tready))
            idle_count = 0;
         else if (++idle_count >= STALL_LIMIT) begin
            $display("%0t: watchdog expired", $realtime);
            $display("particle_pool_integrator_unit verification failed");
            $finish;
         end
      end
   end

   task automatic send_tick(logic [20:0] dt, logic [31:0] ex, logic [31:0] ey);
      while (!quiet_stretch && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b0, ey, ex, dt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [31:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering ticks and let every report drain
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pool.pending_slots.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_all(logic [30:0] rt, logic [30:0] lf, logic [30:0] inv,
                            logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                            logic em, logic run);
      write_csr(CSR_EMISSION_RATE, {1'b0, rt});
      write_csr(CSR_LIFESPAN, {1'b0, lf});
      write_csr(CSR_INV_LIFESPAN, {1'b0, inv});
      write_csr(CSR_GRAVITY_X, gx);
      write_csr(CSR_GRAVITY_Y, gy);
      write_csr(CSR_GRAVITY_Z, gz);
      write_csr(CSR_EMITTING, {31'b0, em});
      write_csr(CSR_RUNNING, {31'b0, run});
   endtask

   task automatic random_ticks(int num);
      logic [20:0] dt;
      repeat (num) begin
         case ($urandom_range(3))
            0: dt = 21'($urandom_range(0, 1048576));
            1: dt = 21'($urandom_range(0, 4096));
            default: dt = 21'($urandom_range(0, 131072));
         endcase
         send_tick(dt, $urandom, $urandom);
      end
   endtask

   initial begin
      pool.reset_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default registers, field extremes, bursts of emission
      send_tick(21'd0, 32'h0, 32'h0);
      send_tick(21'd65536, 32'h7FFFFFFF, 32'h80000000);
      send_tick(21'd1048576, 32'h80000000, 32'h7FFFFFFF);
      send_tick(21'd6554, 32'h00010000, 32'hFFFF0000);
      send_tick(21'd1, 32'hFFFFFFFF, 32'h1);
      send_tick(21'h0FFFFF, 32'h12345678, 32'h9ABCDEF0);
      for (int i = 0; i < 8; i++) send_tick(21'd1048576, $urandom, $urandom);
      drain();

      // extremes: flood emission, shortest life, saturating age and motion
      write_all(31'h7FFFFFFF, 31'd1, 31'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                32'h7FFFFFFF, 1'b1, 1'b1);
      send_tick(21'd1048576, 32'h7FFFFFFF, 32'h80000000);
      send_tick(21'd0, 32'h0, 32'h0);
      send_tick(21'd1048576, 32'h1, 32'h2);
      random_ticks(3);
      drain();

      // no emission, longest life, zero reciprocal
      write_all(31'd0, 31'h7FFFFFFF, 31'd0, 32'h80000000, 32'h7FFFFFFF,
                32'h80000000, 1'b0, 1'b1);
      random_ticks(4);
      drain();

      // frozen pool
      write_all(31'd655360, 31'd655360, 31'd6554, 32'h0, 32'hFFF63064, 32'h0, 1'b1, 1'b0);
      random_ticks(4);
      drain();

      // random phases; one runs without idling, one carries the long hold-off
      for (int ph = 0; ph < 6; ph++) begin
         write_all(31'($urandom_range(0, 2000000)), 31'($urandom_range(1, 3000000)),
                   31'($urandom_range(0, 40000)),
                   $urandom_range(0, 1) ? $urandom : $urandom % 1000000,
                   $urandom % 2000000 - 1000000, $urandom, $urandom_range(0, 9) != 0,
                   $urandom_range(0, 9) != 0);
         quiet_stretch = (ph == 1);
         if (ph == 3) hold_request = 600;
         random_ticks(49);
         quiet_stretch = 0;
         drain();
      end

      $display("covered %0d ticks and %0d slot transactions over several register settings",
               pool.ticks, pool.checked);
      $display("including emission floods, frozen and non-emitting phases and a long stall");
      if (pool.errors == 0 && pool.pending_slots.size() == 0)
         $display("particle_pool_integrator_unit verification clean");
      else
         $display("particle_pool_integrator_unit verification failed");
      $finish;
   end
endmodule
